@@ hdl/bss_pkg.sv @@
// bss_pkg: shared types for the bounded stack with sort
// holds opcode, status and sequencer state codes; no dependencies
`default_nettype none

package bss_pkg;

   // operation codes carried by a request word
   typedef enum logic [1:0] {
      OP_PUSH    = 2'd0,
      OP_POP     = 2'd1,
      OP_REPLACE = 2'd2,
      OP_SORT    = 2'd3
   } opcode_type;

   // result status codes
   typedef enum logic [1:0] {
      ST_OK       = 2'd0,
      ST_OVERFLOW = 2'd1,
      ST_EMPTY    = 2'd2
   } status_type;

   // sequencer states
   typedef enum logic [2:0] {
      S_IDLE,
      S_POP,
      S_RUN,
      S_MCMP,
      S_CRD,
      S_CPY,
      S_TOP_RD,
      S_TOP
   } state_type;

endpackage

`default_nettype wire

@@ hdl/bounded_stack_with_sort.sv @@
// bounded_stack_with_sort: LIFO stack of signed words with scratch-based merge sort
// depends on bss_pkg; stack and merge scratch are synchronous, registered-read memories
//
//   channel  | direction | handshake             | payload
//   ---------+-----------+-----------------------+-------------------------------------
//   req      | in        | req_valid / req_stall | req_opcode, req_word_in
//   rsp      | out       | rsp_valid / rsp_stall | rsp_status, rsp_entries, rsp_top_word
//
// push, replace, failed ops, sort under two entries, pop to empty: answered from S_IDLE
// pop that leaves entries: through S_POP (stack read for the new top)
// sort: doubling-width passes; per run pair S_RUN sets up, S_MCMP merges to the single
// scratch write port and S_CRD/S_CPY copy back, one word per cycle; S_TOP_RD/S_TOP end
// reset clears fill level and control only; memories are not cleared
// req_stall is high while a word is in work or the result register is held by rsp_stall
`default_nettype none

module bounded_stack_with_sort #(
   parameter int DEPTH     = 64,
   parameter int WORD_BITS = 32,
   localparam int CNT_W    = $clog2(DEPTH + 1)
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        req_valid,
   output logic                             req_stall,
   input  wire logic [1:0]                  req_opcode,
   input  wire logic signed [WORD_BITS-1:0] req_word_in,
   output logic                             rsp_valid,
   input  wire logic                        rsp_stall,
   output logic [1:0]                       rsp_status,
   output logic [CNT_W-1:0]                 rsp_entries,
   output logic signed [WORD_BITS-1:0]      rsp_top_word
);

   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int SW     = CNT_W + 2;

   // storage
   logic signed [WORD_BITS-1:0] stack_mem   [DEPTH];
   logic signed [WORD_BITS-1:0] scratch_mem [DEPTH];

   bss_pkg::state_type state_ff, state_in;
   logic [CNT_W-1:0]   fill_ff, fill_in;
   logic signed [WORD_BITS-1:0] top_ff, top_in;
   logic [SW-1:0]      lo_ff, lo_in, width_ff, width_in;
   logic [CNT_W-1:0]   mid_ff, mid_in, hi_ff, hi_in;
   logic [CNT_W-1:0]   l_ff, l_in, r_ff, r_in, k_ff, k_in;
   logic signed [WORD_BITS-1:0] rd_a_ff, rd_b_ff, scr_rd_ff;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [1:0]         rsp_status_ff, rsp_status_in;
   logic [CNT_W-1:0]   rsp_entries_ff, rsp_entries_in;
   logic signed [WORD_BITS-1:0] rsp_top_ff, rsp_top_in;

   logic               accept;
   bss_pkg::opcode_type op;
   logic [SW-1:0]      n_w, lo_mid_w, mid_hi_w, width2_w;
   logic               run_pair, merge_last, copy_last, take_left;
   logic signed [WORD_BITS-1:0] merge_word;
   logic               st_we, scr_we;
   logic [ADDR_W-1:0]  st_waddr, rd_addr_a, rd_addr_b, scr_raddr;
   logic signed [WORD_BITS-1:0] st_wdata;
   logic [CNT_W-1:0]   fill_m1, fill_m2, k_p1;

   assign accept    = req_valid && !req_stall;
   assign req_stall = (state_ff != bss_pkg::S_IDLE) || (rsp_valid_ff && rsp_stall);
   assign op        = bss_pkg::opcode_type'(req_opcode);

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_status   = rsp_status_ff;
   assign rsp_entries  = rsp_entries_ff;
   assign rsp_top_word = rsp_top_ff;

   // run bounds for the merge sequencer
   assign n_w        = SW'(fill_ff);
   assign lo_mid_w   = lo_ff + width_ff;
   assign mid_hi_w   = lo_mid_w + width_ff;
   assign width2_w   = width_ff << 1;
   assign run_pair   = lo_mid_w < n_w;
   assign k_p1       = k_ff + CNT_W'(1);
   assign merge_last = (k_p1 == hi_ff);
   assign copy_last  = (k_p1 == hi_ff);
   assign fill_m1    = fill_ff - CNT_W'(1);
   assign fill_m2    = fill_ff - CNT_W'(2);

   // stable merge choice: left on equal
   assign take_left  = (l_ff < mid_ff) && ((r_ff >= hi_ff) || (rd_a_ff <= rd_b_ff));
   assign merge_word = take_left ? rd_a_ff : rd_b_ff;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         bss_pkg::S_IDLE: begin
            if (accept) begin
               if ((op == bss_pkg::OP_POP) && (fill_ff >= CNT_W'(2))) begin
                  state_in = bss_pkg::S_POP;
               end else if ((op == bss_pkg::OP_SORT) && (fill_ff >= CNT_W'(2))) begin
                  state_in = bss_pkg::S_RUN;
               end
            end
         end
         bss_pkg::S_POP: state_in = bss_pkg::S_IDLE;
         bss_pkg::S_RUN: begin
            if (run_pair) begin
               state_in = bss_pkg::S_MCMP;
            end else if (width2_w >= n_w) begin
               state_in = bss_pkg::S_TOP_RD;
            end
         end
         bss_pkg::S_MCMP: begin
            if (merge_last) state_in = bss_pkg::S_CRD;
         end
         bss_pkg::S_CRD: state_in = bss_pkg::S_CPY;
         bss_pkg::S_CPY: begin
            if (copy_last) state_in = bss_pkg::S_RUN;
         end
         bss_pkg::S_TOP_RD: state_in = bss_pkg::S_TOP;
         bss_pkg::S_TOP: state_in = bss_pkg::S_IDLE;
         default: state_in = bss_pkg::S_IDLE;
      endcase
   end

   // datapath, memory controls and result word
   always_comb begin
      fill_in        = fill_ff;
      top_in         = top_ff;
      lo_in          = lo_ff;
      width_in       = width_ff;
      mid_in         = mid_ff;
      hi_in          = hi_ff;
      l_in           = l_ff;
      r_in           = r_ff;
      k_in           = k_ff;
      rsp_valid_in   = rsp_valid_ff && rsp_stall;
      rsp_status_in  = rsp_status_ff;
      rsp_entries_in = rsp_entries_ff;
      rsp_top_in     = rsp_top_ff;
      st_we          = 1'b0;
      st_waddr       = fill_ff[ADDR_W-1:0];
      st_wdata       = req_word_in;
      scr_we         = 1'b0;
      rd_addr_a      = l_ff[ADDR_W-1:0];
      rd_addr_b      = r_ff[ADDR_W-1:0];
      scr_raddr      = k_ff[ADDR_W-1:0];

      unique case (state_ff)
         bss_pkg::S_IDLE: begin
            rd_addr_a = fill_m2[ADDR_W-1:0];
            if (accept) begin
               rsp_status_in  = bss_pkg::ST_OK;
               rsp_entries_in = fill_ff;
               rsp_top_in     = (fill_ff == '0) ? '0 : top_ff;
               case (op)
                  bss_pkg::OP_PUSH: begin
                     rsp_valid_in = 1'b1;
                     if (fill_ff >= CNT_W'(DEPTH)) begin
                        rsp_status_in = bss_pkg::ST_OVERFLOW;
                     end else begin
                        st_we          = 1'b1;
                        fill_in        = fill_ff + CNT_W'(1);
                        top_in         = req_word_in;
                        rsp_entries_in = fill_ff + CNT_W'(1);
                        rsp_top_in     = req_word_in;
                     end
                  end
                  bss_pkg::OP_POP: begin
                     if (fill_ff == '0) begin
                        rsp_valid_in  = 1'b1;
                        rsp_status_in = bss_pkg::ST_EMPTY;
                     end else begin
                        fill_in = fill_m1;
                        // popping the last entry needs no read
                        if (fill_ff == CNT_W'(1)) begin
                           rsp_valid_in   = 1'b1;
                           rsp_entries_in = '0;
                           rsp_top_in     = '0;
                        end
                     end
                  end
                  bss_pkg::OP_REPLACE: begin
                     rsp_valid_in = 1'b1;
                     if (fill_ff == '0) begin
                        rsp_status_in = bss_pkg::ST_EMPTY;
                     end else begin
                        st_we      = 1'b1;
                        st_waddr   = fill_m1[ADDR_W-1:0];
                        top_in     = req_word_in;
                        rsp_top_in = req_word_in;
                     end
                  end
                  default: begin
                     lo_in    = '0;
                     width_in = SW'(1);
                     // nothing to order with fewer than two entries
                     if (fill_ff < CNT_W'(2)) rsp_valid_in = 1'b1;
                  end
               endcase
            end
         end
         bss_pkg::S_POP: begin
            top_in         = rd_a_ff;
            rsp_valid_in   = 1'b1;
            rsp_status_in  = bss_pkg::ST_OK;
            rsp_entries_in = fill_ff;
            rsp_top_in     = rd_a_ff;
         end
         bss_pkg::S_RUN: begin
            // set up the next run pair, or widen the runs
            if (run_pair) begin
               mid_in = CNT_W'(lo_mid_w);
               hi_in  = (mid_hi_w > n_w) ? fill_ff : CNT_W'(mid_hi_w);
               l_in   = CNT_W'(lo_ff);
               r_in   = CNT_W'(lo_mid_w);
               k_in   = CNT_W'(lo_ff);
            end else begin
               width_in = width2_w;
               lo_in    = '0;
            end
            rd_addr_a = l_in[ADDR_W-1:0];
            rd_addr_b = r_in[ADDR_W-1:0];
         end
         bss_pkg::S_MCMP: begin
            // one merged word to scratch, read ahead for the next
            scr_we = 1'b1;
            if (take_left) begin
               l_in = l_ff + CNT_W'(1);
            end else begin
               r_in = r_ff + CNT_W'(1);
            end
            k_in = merge_last ? CNT_W'(lo_ff) : k_p1;
            rd_addr_a = l_in[ADDR_W-1:0];
            rd_addr_b = r_in[ADDR_W-1:0];
         end
         bss_pkg::S_CRD: begin
            scr_raddr = k_ff[ADDR_W-1:0];
         end
         bss_pkg::S_CPY: begin
            // copy the merged run back, one word a cycle
            st_we     = 1'b1;
            st_waddr  = k_ff[ADDR_W-1:0];
            st_wdata  = scr_rd_ff;
            scr_raddr = k_p1[ADDR_W-1:0];
            k_in      = k_p1;
            if (copy_last) lo_in = lo_ff + width2_w;
         end
         bss_pkg::S_TOP_RD: begin
            rd_addr_a = fill_m1[ADDR_W-1:0];
         end
         bss_pkg::S_TOP: begin
            top_in         = rd_a_ff;
            rsp_valid_in   = 1'b1;
            rsp_status_in  = bss_pkg::ST_OK;
            rsp_entries_in = fill_ff;
            rsp_top_in     = rd_a_ff;
         end
         default: begin
         end
      endcase
   end

   // stack memory: one write, two registered reads
   always_ff @(posedge clock) begin
      if (st_we) stack_mem[st_waddr] <= st_wdata;
      rd_a_ff <= stack_mem[rd_addr_a];
      rd_b_ff <= stack_mem[rd_addr_b];
   end

   // merge scratch memory: one write, one registered read
   always_ff @(posedge clock) begin
      if (scr_we) scratch_mem[k_ff[ADDR_W-1:0]] <= merge_word;
      scr_rd_ff <= scratch_mem[scr_raddr];
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= bss_pkg::S_IDLE;
         fill_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         fill_ff      <= fill_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload and sequencer registers
   always_ff @(posedge clock) begin
      top_ff         <= top_in;
      lo_ff          <= lo_in;
      width_ff       <= width_in;
      mid_ff         <= mid_in;
      hi_ff          <= hi_in;
      l_ff           <= l_in;
      r_ff           <= r_in;
      k_ff           <= k_in;
      rsp_status_ff  <= rsp_status_in;
      rsp_entries_ff <= rsp_entries_in;
      rsp_top_ff     <= rsp_top_in;
   end

endmodule

`default_nettype wire

@@ test/tb_bounded_stack_with_sort.sv @@
// testbench for bounded_stack_with_sort: push, pop, replace-top and sort on a 64-entry stack
// uses bss_pkg for opcode and status codes; an in-file stack tracker predicts every reply
`default_nettype none

// one expected reply word
typedef struct {
   bss_pkg::status_type status;
   logic [6:0]          entries;
   logic signed [31:0]  top_word;
} stack_reply_type;

// shadow stack: applies each accepted op and queues the reply it must produce
class stack_tracker_type;
   localparam int STACK_DEPTH = 64;
   localparam int REPORT_MAX  = 10;

   logic signed [31:0] shadow_words [STACK_DEPTH];
   int                 shadow_fill;
   stack_reply_type    pending_replies [$];
   int                 mismatch_count;

   function new();
      shadow_fill    = 0;
      mismatch_count = 0;
   endfunction

   // stable ascending sort of the live entries
   function void sort_shadow();
      logic signed [31:0] key;
      int                 j;
      for (int i = 1; i < shadow_fill; i++) begin
         key = shadow_words[i];
         j   = i - 1;
         while (j >= 0 && shadow_words[j] > key) begin
            shadow_words[j + 1] = shadow_words[j];
            j--;
         end
         shadow_words[j + 1] = key;
      end
   endfunction

   function void apply_op(bss_pkg::opcode_type op, logic signed [31:0] word);
      stack_reply_type reply;
      reply.status = bss_pkg::ST_OK;
      case (op)
         bss_pkg::OP_PUSH: begin
            if (shadow_fill >= STACK_DEPTH) begin
               reply.status = bss_pkg::ST_OVERFLOW;
            end else begin
               shadow_words[shadow_fill] = word;
               shadow_fill++;
            end
         end
         bss_pkg::OP_POP: begin
            if (shadow_fill == 0) reply.status = bss_pkg::ST_EMPTY;
            else shadow_fill--;
         end
         bss_pkg::OP_REPLACE: begin
            if (shadow_fill == 0) reply.status = bss_pkg::ST_EMPTY;
            else shadow_words[shadow_fill - 1] = word;
         end
         default: begin
            sort_shadow();
         end
      endcase
      reply.entries  = shadow_fill[6:0];
      reply.top_word = (shadow_fill == 0) ? 32'sd0 : shadow_words[shadow_fill - 1];
      pending_replies.insert(pending_replies.size(), reply);
   endfunction

   function void report(string what);
      mismatch_count++;
      if (mismatch_count <= REPORT_MAX) $display("mismatch: %s", what);
   endfunction

   function void check_reply(logic [1:0] status, logic [6:0] entries,
                             logic signed [31:0] top_word);
      stack_reply_type want;
      if (pending_replies.size() == 0) begin
         report($sformatf("unexpected word: status %0d entries %0d top %0d",
                          status, entries, top_word));
         return;
      end
      want = pending_replies.pop_front();
      if (status !== want.status || entries !== want.entries ||
          top_word !== want.top_word)
         report($sformatf("expected status %0d entries %0d top %0d, got %0d %0d %0d",
                          want.status, want.entries, want.top_word,
                          status, entries, top_word));
   endfunction

   function int pending();
      return pending_replies.size();
   endfunction
endclass

module tb_bounded_stack_with_sort;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int RANDOM_ITEMS    = 950;
   localparam int HOLD_OFF_CYCLES = 400;
   localparam int IDLE_LIMIT      = 20000;
   localparam int TAIL_CYCLES     = 100;
   localparam int FULL_LEVEL      = 64;

   localparam logic signed [31:0] WORD_MAX = 32'sh7fff_ffff;
   localparam logic signed [31:0] WORD_MIN = 32'sh8000_0000;

   // phases of the random part
   typedef enum int {PH_FILL, PH_DRAIN, PH_MIXED, PH_NOISE} phase_type;

   logic               clock        = 1'b0;
   logic               reset        = 1'b1;
   logic               req_valid    = 1'b0;
   logic               req_stall;
   logic [1:0]         req_opcode   = bss_pkg::OP_PUSH;
   logic signed [31:0] req_word_in  = 32'sd0;
   logic               rsp_valid;
   logic               rsp_stall    = 1'b0;
   logic [1:0]         rsp_status;
   logic [6:0]         rsp_entries;
   logic signed [31:0] rsp_top_word;

   stack_tracker_type tracker = new();
   bit           hold_off_req  = 1'b0;
   bit           hold_off_done = 1'b0;
   bit           tx_quiet      = 1'b0;
   bit           rx_quiet      = 1'b0;
   int           idle_cycles   = 0;
   int           sent          = 0;

   bounded_stack_with_sort dut (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_opcode   (req_opcode),
      .req_word_in  (req_word_in),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_status   (rsp_status),
      .rsp_entries  (rsp_entries),
      .rsp_top_word (rsp_top_word)
   );

   // 2 ns clock
   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // mostly short gaps, a few long ones
   function automatic int pick_gap();
      int r = $urandom_range(99);
      if (r < 55) return 0;
      if (r < 85) return $urandom_range(3, 1);
      if (r < 97) return $urandom_range(12, 4);
      return $urandom_range(60, 20);
   endfunction

   // extremes, a narrow band with repeats, and full-range words
   function automatic logic signed [31:0] pick_word();
      case ($urandom_range(5))
         0: return WORD_MAX;
         1: return WORD_MIN;
         2: return $urandom_range(16) - 8;
         default: return $urandom;
      endcase
   endfunction

   // offer one word and hold it until the block takes it
   task automatic send_word(bss_pkg::opcode_type op, logic signed [31:0] word);
      int gap;
      gap = tx_quiet ? 0 : pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_opcode  <= op;
      req_word_in <= word;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      tracker.apply_op(op, word);
      sent++;
   endtask

   // mostly pushes and replaces toward full, then a few overflowing pushes and sometimes a sort
   task automatic run_fill();
      while (tracker.shadow_fill < FULL_LEVEL) begin
         if ($urandom_range(9) == 0) send_word(bss_pkg::OP_REPLACE, pick_word());
         else send_word(bss_pkg::OP_PUSH, pick_word());
      end
      repeat ($urandom_range(3, 1)) send_word(bss_pkg::OP_PUSH, pick_word());
      if ($urandom_range(1) == 0) send_word(bss_pkg::OP_SORT, pick_word());
   endtask

   // pops to empty, then pops and replaces on the empty stack
   task automatic run_drain();
      while (tracker.shadow_fill > 0) begin
         if ($urandom_range(7) == 0) send_word(bss_pkg::OP_REPLACE, pick_word());
         else send_word(bss_pkg::OP_POP, pick_word());
      end
      repeat ($urandom_range(2, 1))
         send_word($urandom_range(1) ? bss_pkg::OP_POP : bss_pkg::OP_REPLACE, pick_word());
   endtask

   // weighted mix around small fill levels
   task automatic run_mixed();
      int r;
      repeat ($urandom_range(60, 20)) begin
         r = $urandom_range(99);
         if (r < 40) send_word(bss_pkg::OP_PUSH, pick_word());
         else if (r < 72) send_word(bss_pkg::OP_POP, pick_word());
         else if (r < 90) send_word(bss_pkg::OP_REPLACE, pick_word());
         else send_word(bss_pkg::OP_SORT, pick_word());
      end
   endtask

   // receiver: random stalls, quiet stretches and one long hold-off
   initial begin
      int n;
      forever begin
         if (hold_off_req) begin
            hold_off_req = 1'b0;
            rsp_stall <= 1'b1;
            repeat (HOLD_OFF_CYCLES) @(posedge clock);
         end else begin
            if ($urandom_range(199) == 0) rx_quiet = !rx_quiet;
            n = rx_quiet ? 0 : pick_gap();
            if (n > 0) begin
               rsp_stall <= 1'b1;
               repeat (n) @(posedge clock);
            end
            rsp_stall <= 1'b0;
            @(posedge clock);
         end
      end
   end

   // reply check and watchdog on handshake activity
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && !rsp_stall)
            tracker.check_reply(rsp_status, rsp_entries, rsp_top_word);
         if ((rsp_valid && !rsp_stall) || (req_valid && !req_stall)) idle_cycles <= 0;
         else idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("watchdog: no handshake for %0d cycles", IDLE_LIMIT);
            $display("bounded_stack_with_sort verification failed");
            $finish;
         end
      end
   end

   // stimulus
   initial begin
      phase_type phase;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // directed: empty-stack cases, one-entry sort, extremes, duplicates
      send_word(bss_pkg::OP_POP, 32'sd0);
      send_word(bss_pkg::OP_REPLACE, WORD_MAX);
      send_word(bss_pkg::OP_SORT, WORD_MIN);
      send_word(bss_pkg::OP_PUSH, WORD_MAX);
      send_word(bss_pkg::OP_SORT, 32'sd0);
      send_word(bss_pkg::OP_REPLACE, WORD_MIN);
      send_word(bss_pkg::OP_PUSH, 32'sd0);
      send_word(bss_pkg::OP_PUSH, -32'sd1);
      send_word(bss_pkg::OP_PUSH, WORD_MAX);
      send_word(bss_pkg::OP_PUSH, WORD_MIN);
      send_word(bss_pkg::OP_PUSH, 32'sd1);
      send_word(bss_pkg::OP_PUSH, -32'sd1);
      send_word(bss_pkg::OP_PUSH, 32'sh5555_5555);
      send_word(bss_pkg::OP_REPLACE, 32'shaaaa_aaaa);
      send_word(bss_pkg::OP_SORT, 32'sd0);
      send_word(bss_pkg::OP_POP, 32'sd0);
      send_word(bss_pkg::OP_REPLACE, -32'sd1);
      send_word(bss_pkg::OP_SORT, 32'sd0);
      repeat (7) send_word(bss_pkg::OP_POP, 32'sd0);
      send_word(bss_pkg::OP_POP, 32'sd0);

      // random phases; one fill phase runs under a long receiver hold-off
      sent = 0;
      while (sent < RANDOM_ITEMS) begin
         tx_quiet = ($urandom_range(4) == 0);
         if (sent > RANDOM_ITEMS / 3 && !hold_off_done) begin
            hold_off_done = 1'b1;
            hold_off_req  = 1'b1;
            phase = PH_FILL;
         end else begin
            phase = phase_type'($urandom_range(9) < 3 ? PH_MIXED :
                                $urandom_range(3));
         end
         case (phase)
            PH_FILL:  run_fill();
            PH_DRAIN: run_drain();
            PH_MIXED: run_mixed();
            default: begin
               repeat ($urandom_range(20, 5))
                  send_word(bss_pkg::opcode_type'($urandom_range(3)), $urandom);
            end
         endcase
      end
      req_valid <= 1'b0;

      // drain outstanding replies, then watch for stray ones
      while (tracker.pending() != 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);
      if (tracker.mismatch_count == 0 && tracker.pending() == 0) begin
         $display("bounded_stack_with_sort verification clean");
      end else begin
         $display("bounded_stack_with_sort verification failed");
      end
      $finish;
   end

endmodule

`default_nettype wire
